// ===== rtl/http_request_header_parser_core_macros.svh =====
// Assertion helpers for the request header parser.
`ifndef HTTP_REQUEST_HEADER_PARSER_CORE_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HRP_ASSERT_IMPLY(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("hrp: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HRP_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("hrp: next-cycle check failed");

`endif

// ===== rtl/hrp_pkg.sv =====
package hrp_pkg;

   // Character constants
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UC_A  = 8'h41;
   localparam logic [7:0] CH_UC_Z  = 8'h5A;
   localparam logic [7:0] CH_UC_H  = 8'h48;
   localparam logic [7:0] CH_UC_T  = 8'h54;
   localparam logic [7:0] CH_UC_P  = 8'h50;

   // Field classes
   localparam logic [2:0] CLS_NONE    = 3'd0;
   localparam logic [2:0] CLS_METHOD  = 3'd1;
   localparam logic [2:0] CLS_PATH    = 3'd2;
   localparam logic [2:0] CLS_VERSION = 3'd3;
   localparam logic [2:0] CLS_KEY     = 3'd4;
   localparam logic [2:0] CLS_VALUE   = 3'd5;

   // Parse status codes
   localparam logic [1:0] STS_MORE  = 2'd0;
   localparam logic [1:0] STS_DONE  = 2'd1;
   localparam logic [1:0] STS_ERROR = 2'd2;

   localparam logic [9:0]  VER_MAX         = 10'd999;
   localparam logic [15:0] MAX_PATH_RESET  = 16'd1024;
   localparam logic        CSR_IDX_MAX_PATH = 1'b0;

   // Queue between classifier and engine
   localparam int QUEUE_DEPTH = 2;

   // Pre-decoded character flags
   typedef struct packed {
      logic is_cr;
      logic is_lf;
      logic is_sp;
      logic is_tab;
      logic is_slash;
      logic is_colon;
      logic is_dot;
      logic is_digit;
      logic is_digit19;
      logic is_upper;
      logic is_h;
      logic is_t;
      logic is_p;
   } chr_type;

   // One classified transaction as queued
   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_request;
      chr_type    chr;
   } item_type;

   // Queue occupancy status
   typedef struct packed {
      logic                               full;
      logic                               empty;
      logic [$clog2(QUEUE_DEPTH+1)-1:0]   count;
   } queue_status_type;

   typedef enum logic [21:0] {
      PH_START     = 22'b0000000000000000000001,
      PH_METHOD    = 22'b0000000000000000000010,
      PH_SP_PATH   = 22'b0000000000000000000100,
      PH_PATH      = 22'b0000000000000000001000,
      PH_SP_VER    = 22'b0000000000000000010000,
      PH_H         = 22'b0000000000000000100000,
      PH_HT        = 22'b0000000000000001000000,
      PH_HTT       = 22'b0000000000000010000000,
      PH_HTTP      = 22'b0000000000000100000000,
      PH_MAJ_FIRST = 22'b0000000000001000000000,
      PH_MAJ       = 22'b0000000000010000000000,
      PH_MIN_FIRST = 22'b0000000000100000000000,
      PH_MIN       = 22'b0000000001000000000000,
      PH_RL_CR     = 22'b0000000010000000000000,
      PH_RL_DONE   = 22'b0000000100000000000000,
      PH_KEY       = 22'b0000001000000000000000,
      PH_SEP       = 22'b0000010000000000000000,
      PH_VALUE     = 22'b0000100000000000000000,
      PH_KV_CR     = 22'b0001000000000000000000,
      PH_KV_DONE   = 22'b0010000000000000000000,
      PH_END_CR    = 22'b0100000000000000000000,
      PH_DONE      = 22'b1000000000000000000000
   } phase_type;

   // Append one decimal digit, saturating at the version limit
   function automatic logic [9:0] dec_push(input logic [9:0] acc, input logic [3:0] digit);
      logic [13:0] v;
      v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {10'b0, digit};
      dec_push = (v > {4'b0, VER_MAX}) ? VER_MAX : v[9:0];
   endfunction

endpackage

// ===== rtl/http_request_header_parser_core.sv =====
// Channel   | Direction | Ports                        | Content
// req       | in        | req_tvalid/tready/tdata/user | one request byte per transaction
// rsp       | out       | rsp_tvalid/tready/tdata/...  | one parse result per byte
// csr       | in/out    | csr_psel ... csr_pready      | max_path_length register
//
// Sustained rate is one byte per clock while rsp_tready stays high; an accepted byte
// is decoded on its way into the two-entry queue, then the parse engine's state
// transition loads its result into the output register.
// Synchronous active-high reset clears the parser, the queue and the valid flags
// and restores max_path_length to 1024.
// A stalled result holds in the output register; req_tready drops once the queue is full.
`include "http_request_header_parser_core_macros.svh"

module http_request_header_parser_core
   import hrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Request byte stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] new_request
   // Parse results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] byte_echo, [9:8] parse_status,
                                    // [19:10] version_major, [29:20] version_minor
   output logic [2:0]  rsp_tuser,   // [2:0] field_class
   output logic        rsp_tlast,   // field_end
   // Configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [15:0]      max_path_ff, max_path_in;
   logic             csr_write;
   item_type         front_item;
   item_type         queue_item;
   queue_status_type queue_status;
   logic             queue_pop;
   logic [7:0]       byte_echo;
   logic [2:0]       field_class;
   logic             field_end;
   logic [1:0]       parse_status;
   logic [9:0]       version_major;
   logic [9:0]       version_minor;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_IDX_MAX_PATH);
   assign max_path_in = csr_write ? csr_pwdata[15:0] : max_path_ff;
   assign csr_prdata  = (csr_paddr[2] == CSR_IDX_MAX_PATH) ? {16'b0, max_path_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_path_ff <= MAX_PATH_RESET;
      end else begin
         max_path_ff <= max_path_in;
      end
   end

   // Front: classify the incoming byte
   hrp_front u_front (
      .data_byte   (req_tdata),
      .new_request (req_tuser[0]),
      .item        (front_item)
   );

   assign req_tready = !queue_status.full;

   hrp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_item (front_item),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .status    (queue_status)
   );

   // Back: run the parser state machine
   hrp_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .max_path_length (max_path_ff),
      .item_valid      (!queue_status.empty),
      .item            (queue_item),
      .item_pop        (queue_pop),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .byte_echo       (byte_echo),
      .field_class     (field_class),
      .field_end       (field_end),
      .parse_status    (parse_status),
      .version_major   (version_major),
      .version_minor   (version_minor)
   );

   assign rsp_tdata = {2'b0, version_minor, version_major, parse_status, byte_echo};
   assign rsp_tuser = field_class;
   assign rsp_tlast = field_end;

   // Checks
   `HRP_ASSERT_IMPLY(a_err_no_field, clock, reset,
      rsp_tvalid && (parse_status == STS_ERROR), (field_class == CLS_NONE) && !field_end)
   `HRP_ASSERT_IMPLY(a_done_no_field, clock, reset,
      rsp_tvalid && (parse_status == STS_DONE), (field_class == CLS_NONE) && !field_end)
   `HRP_ASSERT_IMPLY(a_end_has_class, clock, reset,
      rsp_tvalid && field_end, field_class != CLS_NONE)
   `HRP_ASSERT_NEXT(a_queue_fills, clock, reset,
      req_tvalid && req_tready && !queue_pop, !queue_status.empty)

endmodule

// ===== rtl/hrp_front.sv =====
module hrp_front
   import hrp_pkg::*;
(
   input  logic [7:0] data_byte,
   input  logic       new_request,
   output item_type   item
);

   chr_type chr;

   // Decode the character classes the engine branches on
   always_comb begin
      chr.is_cr      = (data_byte == CH_CR);
      chr.is_lf      = (data_byte == CH_LF);
      chr.is_sp      = (data_byte == CH_SP);
      chr.is_tab     = (data_byte == CH_TAB);
      chr.is_slash   = (data_byte == CH_SLASH);
      chr.is_colon   = (data_byte == CH_COLON);
      chr.is_dot     = (data_byte == CH_DOT);
      chr.is_digit   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
      chr.is_digit19 = (data_byte >= CH_ONE) && (data_byte <= CH_NINE);
      chr.is_upper   = (data_byte >= CH_UC_A) && (data_byte <= CH_UC_Z);
      chr.is_h       = (data_byte == CH_UC_H);
      chr.is_t       = (data_byte == CH_UC_T);
      chr.is_p       = (data_byte == CH_UC_P);
   end

   assign item.data_byte   = data_byte;
   assign item.new_request = new_request;
   assign item.chr         = chr;

endmodule

// ===== rtl/hrp_queue.sv =====
module hrp_queue
   import hrp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         pop_item,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;

   assign pop_item = entry_ff[rd_ptr_ff];

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/hrp_engine.sv =====
module hrp_engine
   import hrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] max_path_length,
   input  logic        item_valid,
   input  item_type    item,
   output logic        item_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  byte_echo,
   output logic [2:0]  field_class,
   output logic        field_end,
   output logic [1:0]  parse_status,
   output logic [9:0]  version_major,
   output logic [9:0]  version_minor
);

   phase_type   phase_ff, phase_in;
   logic [15:0] path_count_ff, path_count_in;
   logic [9:0]  major_ff, major_in;
   logic [9:0]  minor_ff, minor_in;
   logic        error_ff, error_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  byte_ff;
   logic [2:0]  class_ff;
   logic        fend_ff;
   logic [1:0]  status_ff;
   logic [9:0]  vmaj_ff, vmin_ff;

   phase_type   ph;
   logic [15:0] pc;
   logic        err;
   logic        bad;
   logic [2:0]  cls;
   logic        fend;
   logic [1:0]  status;
   logic        path_full;
   logic [3:0]  digit;
   chr_type     c;

   // Take the next transaction whenever the output register frees up
   assign item_pop     = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = item_pop || (rsp_valid_ff && !rsp_ready);

   assign c         = item.chr;
   assign digit     = item.data_byte[3:0];
   assign ph        = item.new_request ? PH_START : phase_ff;
   assign pc        = item.new_request ? 16'd0 : path_count_ff;
   assign err       = item.new_request ? 1'b0 : error_ff;
   assign path_full = (pc >= max_path_length);

   // Per-byte transition of the request parser
   always_comb begin
      phase_in      = ph;
      path_count_in = pc;
      major_in      = item.new_request ? 10'd0 : major_ff;
      minor_in      = item.new_request ? 10'd0 : minor_ff;
      bad           = 1'b0;
      cls           = CLS_NONE;
      fend          = 1'b0;
      if (!err) begin
         unique case (ph)
            PH_START: begin
               if (c.is_cr || c.is_lf) begin
                  phase_in = PH_RL_DONE;
               end else if (c.is_upper) begin
                  phase_in = PH_METHOD;
                  cls      = CLS_METHOD;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_METHOD: begin
               if (c.is_sp) begin
                  phase_in = PH_SP_PATH;
                  cls      = CLS_METHOD;
                  fend     = 1'b1;
               end else if (c.is_upper) begin
                  cls = CLS_METHOD;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_SP_PATH: begin
               if (!c.is_sp) begin
                  if (!c.is_slash || path_full) begin
                     bad = 1'b1;
                  end else begin
                     path_count_in = pc + 16'd1;
                     phase_in      = PH_PATH;
                     cls           = CLS_PATH;
                  end
               end
            end
            PH_PATH: begin
               if (c.is_sp) begin
                  phase_in = PH_SP_VER;
                  cls      = CLS_PATH;
                  fend     = 1'b1;
               end else if (path_full) begin
                  bad = 1'b1;
               end else begin
                  path_count_in = pc + 16'd1;
                  cls           = CLS_PATH;
               end
            end
            PH_SP_VER: begin
               if (!c.is_sp) begin
                  if (c.is_h) begin
                     phase_in = PH_H;
                     cls      = CLS_VERSION;
                  end else begin
                     bad = 1'b1;
                  end
               end
            end
            PH_H: begin
               if (c.is_t) begin
                  phase_in = PH_HT;
                  cls      = CLS_VERSION;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_HT: begin
               if (c.is_t) begin
                  phase_in = PH_HTT;
                  cls      = CLS_VERSION;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_HTT: begin
               if (c.is_p) begin
                  phase_in = PH_HTTP;
                  cls      = CLS_VERSION;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_HTTP: begin
               if (c.is_slash) begin
                  phase_in = PH_MAJ_FIRST;
                  cls      = CLS_VERSION;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_MAJ_FIRST: begin
               if (c.is_digit19) begin
                  major_in = {6'b0, digit};
                  phase_in = PH_MAJ;
                  cls      = CLS_VERSION;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_MAJ: begin
               if (c.is_dot) begin
                  phase_in = PH_MIN_FIRST;
                  cls      = CLS_VERSION;
               end else if (c.is_digit) begin
                  major_in = dec_push(major_in, digit);
                  cls      = CLS_VERSION;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_MIN_FIRST: begin
               if (c.is_digit) begin
                  minor_in = {6'b0, digit};
                  phase_in = PH_MIN;
                  cls      = CLS_VERSION;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_MIN: begin
               if (c.is_cr) begin
                  phase_in = PH_RL_CR;
                  cls      = CLS_VERSION;
                  fend     = 1'b1;
               end else if (c.is_digit) begin
                  minor_in = dec_push(minor_in, digit);
                  cls      = CLS_VERSION;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_RL_CR: begin
               if (c.is_lf) begin
                  phase_in = PH_RL_DONE;
               end
            end
            PH_RL_DONE: begin
               if (c.is_cr) begin
                  phase_in = PH_END_CR;
               end else begin
                  phase_in = PH_KEY;
                  cls      = CLS_KEY;
               end
            end
            PH_KEY: begin
               cls = CLS_KEY;
               if (c.is_colon) begin
                  phase_in = PH_SEP;
                  fend     = 1'b1;
               end
            end
            PH_KV_DONE: begin
               if (c.is_cr) begin
                  phase_in = PH_END_CR;
               end else if (!c.is_lf) begin
                  cls = CLS_KEY;
                  if (c.is_colon) begin
                     phase_in = PH_SEP;
                     fend     = 1'b1;
                  end else begin
                     phase_in = PH_KEY;
                  end
               end
            end
            PH_SEP: begin
               if (!c.is_sp && !c.is_tab) begin
                  phase_in = PH_VALUE;
                  cls      = CLS_VALUE;
               end
            end
            PH_VALUE: begin
               cls = CLS_VALUE;
               if (c.is_cr) begin
                  phase_in = PH_KV_CR;
                  fend     = 1'b1;
               end
            end
            PH_KV_CR: begin
               if (c.is_lf) begin
                  phase_in = PH_KV_DONE;
               end
            end
            PH_END_CR: begin
               if (c.is_lf) begin
                  phase_in = PH_DONE;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_DONE: begin
            end
            default: begin
            end
         endcase
         // Drop the field marking on an error byte
         if (bad) begin
            cls  = CLS_NONE;
            fend = 1'b0;
         end
      end
      error_in = err || bad;
      if (error_in) begin
         status = STS_ERROR;
      end else if (phase_in == PH_DONE) begin
         status = STS_DONE;
      end else begin
         status = STS_MORE;
      end
   end

   // Parser state, updated once per popped transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         path_count_ff <= '0;
         major_ff      <= '0;
         minor_ff      <= '0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_pop) begin
            phase_ff      <= phase_in;
            path_count_ff <= path_count_in;
            major_ff      <= major_in;
            minor_ff      <= minor_in;
            error_ff      <= error_in;
         end
      end
   end

   // Output register, held while the result is stalled
   always_ff @(posedge clock) begin
      if (item_pop) begin
         byte_ff   <= item.data_byte;
         class_ff  <= cls;
         fend_ff   <= fend;
         status_ff <= status;
         vmaj_ff   <= major_in;
         vmin_ff   <= minor_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign byte_echo     = byte_ff;
   assign field_class   = class_ff;
   assign field_end     = fend_ff;
   assign parse_status  = status_ff;
   assign version_major = vmaj_ff;
   assign version_minor = vmin_ff;

endmodule
